// File: src/mm3h_pkg.sv
// Package with the hash constants, sequencer states and multiplier request type.
package mm3h_pkg;

  localparam logic [31:0] SEED_RESET = 32'h2BF9_D07B;
  localparam logic [31:0] MM_C1      = 32'hCC9E_2D51;
  localparam logic [31:0] MM_C2      = 32'h1B87_3593;
  localparam logic [31:0] MM_N       = 32'hE654_6B64;
  localparam logic [31:0] MM_F1      = 32'h85EB_CA6B;
  localparam logic [31:0] MM_F2      = 32'hC2B2_AE35;

  localparam logic [2:0] BYTES_FULL = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_FIN0,
    ST_FIN1,
    ST_FIN2
  } mm3h_state_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

// File: src/mm3h_mul.sv
// Shared 32x32 multiplier keeping the low 32 product bits in a register.
module mm3h_mul (
  input  logic              clk,
  input  mm3h_pkg::mul_req_t req,
  output logic [31:0]       product
);
  import mm3h_pkg::*;

  logic [31:0] low_product;

  // Every use of the product works modulo 2^32, so only the low half is formed.
  assign low_product = req.a * req.b;

  // The product register holds its value while no request is issued.
  always_ff @(posedge clk) begin
    if (req.en) begin
      product <= low_product;
    end
  end

endmodule

// File: src/murmur3_32bit_key_hash.sv
// Top level of the MurmurHash3 x86_32 key hasher with its sequencer.
//
// This block hashes keys that arrive as streams of 32-bit little-endian words
// and returns one MurmurHash3 x86_32 value per key. Each input item carries
// the key word and a count of valid low bytes in tdata and the last mark in
// tlast. A count of four is a full word; a count of zero to three ends the
// key as a tail, even without the last mark, and counts above four are
// treated as four. The hash starts from the seed register when the first word
// of a key is accepted, so a seed write made in the middle of a key only
// affects the next key. All multiplies go through one shared 32x32 multiplier
// with a registered product, driven by a small sequencer. A full word that is
// not the last passes through the accept step, two dependent constant
// multiplies and the mix step before the block is ready again. A word that
// ends the key adds the finalizer with its two multiplies; a zero-byte word
// skips the constant multiplies and the mix and goes straight to the
// finalizer. The finished hash sits in an output register; the block takes
// the next item while it waits, and only stalls when a second hash is ready
// before the first one has been taken.
module murmur3_32bit_key_hash (
  input  logic        clk,
  input  logic        rst,
  // Seed register write port.
  input  logic        seed_wen,
  input  logic [31:0] seed_wdata,
  // Input items: tdata = {5'b0, byte_count[2:0], key_word[31:0]}, tlast = last_word.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  // Result items: tdata = hash_value[31:0].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);
  import mm3h_pkg::*;

  mm3h_state_t state, state_next;

  logic [31:0] seed;
  logic [31:0] hash, hash_next;
  logic [31:0] total, total_next;
  logic [31:0] key, key_next;
  logic        in_key, in_key_next;
  logic        full, full_next;
  logic        fin, fin_next;
  logic        out_valid, out_valid_next;
  logic [31:0] out_data, out_data_next;

  mul_req_t    mul_req;
  logic [31:0] product;

  logic [31:0] in_word;
  logic [2:0]  in_count;
  logic [2:0]  count_eff;
  logic [31:0] masked_word;
  logic [31:0] mixed;
  logic [31:0] fin_t;

  assign in_word  = s_tdata[31:0];
  assign in_count = s_tdata[34:32];

  // Counts of five to seven behave like a full word.
  assign count_eff = in_count[2] ? BYTES_FULL : in_count;

  // Bytes above the count are dropped from a tail word.
  always_comb begin
    case (count_eff)
      3'd0:    masked_word = 32'd0;
      3'd1:    masked_word = {24'd0, in_word[7:0]};
      3'd2:    masked_word = {16'd0, in_word[15:0]};
      3'd3:    masked_word = {8'd0, in_word[23:0]};
      default: masked_word = in_word;
    endcase
  end

  // Body mix step: h ^= k, rotate left by 13, then h * 5 + n as shift and add.
  logic [31:0] mix_x;
  logic [31:0] mix_r;
  assign mix_x = hash ^ product;
  assign mix_r = {mix_x[18:0], mix_x[31:19]};
  assign mixed = mix_r + {mix_r[29:0], 2'b00} + MM_N;

  // First finalizer step: fold in the length, then h ^= h >> 16.
  assign fin_t = hash ^ total;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  mm3h_mul u_mul (
    .clk     (clk),
    .req     (mul_req),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_wen) begin
      seed <= seed_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_key    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_key    <= in_key_next;
      out_valid <= out_valid_next;
    end
    hash     <= hash_next;
    total    <= total_next;
    key      <= key_next;
    full     <= full_next;
    fin      <= fin_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    hash_next      = hash;
    total_next     = total;
    key_next       = key;
    in_key_next    = in_key;
    full_next      = full;
    fin_next       = fin;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    mul_req        = '{en: 1'b0, a: key, b: MM_C1};

    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          // A new key starts from the seed, with the length set to this word's count.
          if (!in_key) begin
            hash_next  = seed;
            total_next = {29'd0, count_eff};
          end else begin
            total_next = total + {29'd0, count_eff};
          end
          in_key_next = 1'b1;
          key_next    = masked_word;
          full_next   = count_eff[2];
          fin_next    = s_tlast || !count_eff[2];
          state_next  = (count_eff == 3'd0) ? ST_FIN0 : ST_MUL1;
        end
      end
      ST_MUL1: begin
        mul_req    = '{en: 1'b1, a: key, b: MM_C1};
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        mul_req    = '{en: 1'b1, a: {product[16:0], product[31:17]}, b: MM_C2};
        state_next = ST_MIX;
      end
      ST_MIX: begin
        // A full word runs the body mix; a tail word is only XORed in.
        hash_next  = full ? mixed : mix_x;
        state_next = fin ? ST_FIN0 : ST_IDLE;
      end
      ST_FIN0: begin
        mul_req    = '{en: 1'b1, a: fin_t ^ {16'd0, fin_t[31:16]}, b: MM_F1};
        state_next = ST_FIN1;
      end
      ST_FIN1: begin
        mul_req    = '{en: 1'b1, a: product ^ {13'd0, product[31:13]}, b: MM_F2};
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        // Wait here only if an earlier hash still sits in the output register.
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = product ^ {16'd0, product[31:16]};
          in_key_next    = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
